### hdl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property holds at every clock edge outside reset.
`define MOI_ASSERT_NOW(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("moi assertion failed");

// When the antecedent holds, the consequent holds in the next cycle.
`define MOI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) ante |=> cons) \
    else $error("moi assertion failed");

`endif

### hdl/moi_pkg.sv
package moi_pkg;

  localparam int FRAC_BITS        = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES     = 24;

  localparam longint WHEEL_K =
    (64'sd239763 * (64'sd1 <<< FRAC_BITS) + 64'sd5000000) / 64'sd10000000;
  localparam int KW = 12;

  localparam logic [25:0] HEAD_CQ    = 26'd44798134;
  localparam int          HEAD_SHIFT = FRAC_BITS + 16 - 20;

  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
  localparam int                 VEL_SHIFT = 18;
  localparam int                 Q30_SHIFT = 30;

  // Division by one million is a shift by six followed by a multiply with the
  // rounded-up reciprocal of 15625, exact for dividends below 2^48.
  localparam int          DT_POW2_SHIFT  = 6;
  localparam logic [42:0] DT_RECIP       = 43'd4611686018428;
  localparam int          DT_RECIP_SHIFT = 56;

  localparam int DIV_NW = 56;
  localparam int DIV_DW = 20;

  localparam logic REG_RADIUS = 1'b0;
  localparam logic REG_LEVER  = 1'b1;

  typedef struct packed {
    logic signed [18:0] sum_x;
    logic signed [18:0] sum_y;
    logic signed [18:0] sum_w;
    logic [19:0]        elapsed;
  } moi_req_t;

  function automatic logic [29:0] moi_atan(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:    v = 30'd536870912;
      5'd1:    v = 30'd316933406;
      5'd2:    v = 30'd167458907;
      5'd3:    v = 30'd85004756;
      5'd4:    v = 30'd42667331;
      5'd5:    v = 30'd21354465;
      5'd6:    v = 30'd10679838;
      5'd7:    v = 30'd5340245;
      5'd8:    v = 30'd2670163;
      5'd9:    v = 30'd1335087;
      5'd10:   v = 30'd667544;
      5'd11:   v = 30'd333772;
      5'd12:   v = 30'd166886;
      5'd13:   v = 30'd83443;
      5'd14:   v = 30'd41722;
      5'd15:   v = 30'd20861;
      5'd16:   v = 30'd10430;
      5'd17:   v = 30'd5215;
      5'd18:   v = 30'd2608;
      5'd19:   v = 30'd1304;
      5'd20:   v = 30'd652;
      5'd21:   v = 30'd326;
      5'd22:   v = 30'd163;
      5'd23:   v = 30'd81;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

### hdl/moi_front.sv
module moi_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [15:0]      speed_front_left_i,
  input  logic signed [15:0]      speed_front_right_i,
  input  logic signed [15:0]      speed_rear_left_i,
  input  logic signed [15:0]      speed_rear_right_i,
  input  logic [19:0]             elapsed_us_i,
  output logic                    req_valid_o,
  output moi_pkg::moi_req_t       req_o,
  input  logic                    req_pop_i
);
  import moi_pkg::*;

  moi_req_t           mem_q [2];
  logic               wr_ptr_q, rd_ptr_q;
  logic [1:0]         cnt_q;
  logic               push;
  logic signed [18:0] a, b, c, d;
  moi_req_t           entry;

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign req_valid_o = (cnt_q != 2'd0);
  assign req_o       = mem_q[rd_ptr_q];

  always_comb begin
    a = 19'(speed_front_left_i);
    b = 19'(speed_front_right_i);
    c = 19'(speed_rear_left_i);
    d = 19'(speed_rear_right_i);
    entry.sum_x   = a - b - c + d;
    entry.sum_y   = -a - b - c - d;
    entry.sum_w   = -a - b + c + d;
    entry.elapsed = elapsed_us_i;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (req_pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !req_pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (!push && req_pop_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

### hdl/moi_div.sv
module moi_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [moi_pkg::DIV_NW-1:0]  num_i,
  input  logic [moi_pkg::DIV_DW-1:0]  den_i,
  output logic                        done_o,
  output logic [moi_pkg::DIV_NW-1:0]  quo_o
);
  import moi_pkg::*;

  localparam int CW = $clog2(DIV_NW + 1);

  logic              busy_q, done_q;
  logic [CW-1:0]     cnt_q;
  logic [DIV_NW-1:0] quo_q;
  logic [DIV_DW-1:0] rem_q, den_q;
  logic [DIV_DW:0]   trial, diff;
  logic              ge;

  assign trial  = {rem_q, quo_q[DIV_NW-1]};
  assign diff   = trial - {1'b0, den_q};
  assign ge     = (trial >= {1'b0, den_q});
  assign done_o = done_q;
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DIV_NW);
        quo_q  <= num_i;
        rem_q  <= '0;
        den_q  <= den_i;
      end else if (busy_q) begin
        rem_q <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
        quo_q <= {quo_q[DIV_NW-2:0], ge};
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

### hdl/moi_cordic.sv
module moi_cordic #(
  parameter int STEPS = moi_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [31:0]        angle_i,
  output logic               done_o,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);
  import moi_pkg::*;

  localparam int CW = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic               busy_q, done_q, flip_q;
  logic [CW-1:0]      i_q;
  logic signed [33:0] x_q, y_q, xs, ys, cx, sy;
  logic signed [32:0] z_q, at;
  logic [31:0]        turned, ang;
  logic               flip;

  assign turned = angle_i + 32'h4000_0000;
  assign flip   = turned[31];
  assign ang    = {angle_i[31] ^ flip, angle_i[30:0]};
  assign xs     = x_q >>> i_q;
  assign ys     = y_q >>> i_q;
  assign at     = signed'({3'b000, moi_atan(5'(i_q))});
  assign cx     = flip_q ? -x_q : x_q;
  assign sy     = flip_q ? -y_q : y_q;
  assign cos_o  = cx[31:0];
  assign sin_o  = sy[31:0];
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      flip_q <= 1'b0;
      i_q    <= '0;
      x_q    <= '0;
      y_q    <= '0;
      z_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        flip_q <= flip;
        i_q    <= '0;
        x_q    <= CORDIC_X0;
        y_q    <= '0;
        z_q    <= signed'({ang[31], ang});
      end else if (busy_q) begin
        if (!z_q[32]) begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - at;
        end else begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + at;
        end
        i_q <= i_q + CW'(1);
        if (i_q == CW'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

### hdl/moi_back.sv
module moi_back #(
  parameter int CORDIC_STEPS = moi_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  input  moi_pkg::moi_req_t  req_i,
  output logic               req_pop_o,
  input  logic [15:0]        radius_i,
  input  logic [17:0]        lever_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] body_vel_x_o,
  output logic signed [31:0] body_vel_y_o,
  output logic signed [31:0] body_yaw_rate_o,
  output logic signed [47:0] position_x_o,
  output logic signed [47:0] position_y_o,
  output logic [31:0]        heading_angle_o
);
  import moi_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_KR, S_VX, S_VY, S_VW, S_DIVW, S_CORD, S_M1, S_M2, S_M3, S_M4,
    S_XD, S_XM, S_XW, S_YD, S_YM, S_YW, S_H1, S_H2, S_H3, S_DONE
  } state_e;

  state_e             state_q;
  moi_req_t           req_q;
  logic [26:0]        kr_q;
  logic signed [31:0] vx_q, vy_q, vw_q;
  logic signed [63:0] prod_q;
  logic signed [34:0] rx_q, ry_q;
  logic signed [47:0] pose_x_q, pose_y_q;
  logic [31:0]        head_q;
  logic [51:0]        pmag_q;
  logic               pneg_q, neg_q;
  logic [57:0]        hi_q;
  logic [41:0]        rn_q;
  logic [84:0]        acc_q;
  logic [1:0]         mstep_q;

  logic               out_valid_q;
  logic signed [31:0] out_vx_q, out_vy_q, out_vw_q;
  logic signed [47:0] out_px_q, out_py_q;
  logic [31:0]        out_head_q;

  logic signed [27:0] kr_s;
  logic signed [18:0] sum_sel;
  logic signed [47:0] kin_prod, kin_adj, kin_sh, kin_abs;
  logic signed [20:0] dt_s;
  logic signed [34:0] pos_sel;
  logic signed [55:0] pos_prod, pos_abs;
  logic               div_start, div_done;
  logic [DIV_NW-1:0]  div_num, div_quo, q_mag;
  logic [DIV_DW-1:0]  div_den;
  logic [17:0]        lev_eff;
  logic signed [56:0] q_s;
  logic signed [57:0] psum;
  logic [20:0]        pp_a;
  logic [21:0]        pp_b;
  logic [42:0]        pp;
  logic [84:0]        pp_sh;
  logic               cord_start, cord_done;
  logic signed [31:0] cos_v, sin_v, mul_a, mul_b;
  logic signed [63:0] mprod;
  logic signed [64:0] dsum, dadj, dsh;
  logic signed [52:0] h_prod, h_abs;
  logic [57:0]        hi_prod;
  logic [45:0]        lo_prod;
  logic [58:0]        hsum;
  logic [31:0]        inc;
  logic               load_out;

  function automatic logic signed [31:0] sat32(input logic signed [56:0] v);
    if (v > 57'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (v < -57'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [57:0] v);
    if (v > 58'sd140737488355327) begin
      return 48'sh7fff_ffff_ffff;
    end else if (v < -58'sd140737488355328) begin
      return 48'sh8000_0000_0000;
    end
    return v[47:0];
  endfunction

  always_comb begin
    kr_s    = signed'({1'b0, kr_q});
    sum_sel = (state_q == S_VX) ? req_q.sum_x :
              (state_q == S_VY) ? req_q.sum_y : req_q.sum_w;
    kin_prod = sum_sel * kr_s;
    kin_adj  = kin_prod + (kin_prod[47] ? 48'sd262143 : 48'sd0);
    kin_sh   = kin_adj >>> VEL_SHIFT;
    kin_abs  = kin_prod[47] ? -kin_prod : kin_prod;

    dt_s     = signed'({1'b0, req_q.elapsed});
    pos_sel  = (state_q == S_XD) ? rx_q : ry_q;
    pos_prod = pos_sel * dt_s;
    pos_abs  = pos_prod[55] ? -pos_prod : pos_prod;

    pp_a = mstep_q[1] ? rn_q[41:21] : rn_q[20:0];
    pp_b = mstep_q[0] ? DT_RECIP[42:21] : {1'b0, DT_RECIP[20:0]};
    pp   = pp_a * pp_b;
    unique case (mstep_q)
      2'd0:       pp_sh = {42'd0, pp};
      2'd1, 2'd2: pp_sh = {21'd0, pp, 21'd0};
      default:    pp_sh = {pp, 42'd0};
    endcase

    lev_eff   = (lever_i == 18'd0) ? 18'd1 : lever_i;
    div_start = (state_q == S_VW);
    div_num   = {8'd0, kin_abs};
    div_den   = {lev_eff, 2'b00};
    q_mag     = (state_q == S_DIVW) ? div_quo : DIV_NW'(acc_q[84:DT_RECIP_SHIFT]);
    q_s       = neg_q ? -signed'({1'b0, q_mag}) : signed'({1'b0, q_mag});
    psum      = 58'((state_q == S_XW) ? pose_x_q : pose_y_q) + 58'(q_s);

    cord_start = (state_q == S_DIVW) && div_done;
    mul_a = ((state_q == S_M1) || (state_q == S_M3)) ? vx_q : vy_q;
    mul_b = ((state_q == S_M1) || (state_q == S_M4)) ? cos_v : sin_v;
    mprod = mul_a * mul_b;
    dsum  = (state_q == S_M2) ? 65'(prod_q) - 65'(mprod) : 65'(prod_q) + 65'(mprod);
    dadj  = dsum + (dsum[64] ? 65'sd1073741823 : 65'sd0);
    dsh   = dadj >>> Q30_SHIFT;

    h_prod  = vw_q * dt_s;
    h_abs   = h_prod[52] ? -h_prod : h_prod;
    hi_prod = pmag_q[51:20] * HEAD_CQ;
    lo_prod = pmag_q[19:0] * HEAD_CQ;
    hsum    = 59'(hi_q) + 59'(lo_prod[45:20]);
    inc     = hsum[HEAD_SHIFT+31:HEAD_SHIFT];

    load_out  = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
    req_pop_o = (state_q == S_IDLE) && req_valid_i;
  end

  moi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  moi_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_start),
    .angle_i (head_q),
    .done_o  (cord_done),
    .cos_o   (cos_v),
    .sin_o   (sin_v)
  );

  assign out_valid_o     = out_valid_q;
  assign body_vel_x_o    = out_vx_q;
  assign body_vel_y_o    = out_vy_q;
  assign body_yaw_rate_o = out_vw_q;
  assign position_x_o    = out_px_q;
  assign position_y_o    = out_py_q;
  assign heading_angle_o = out_head_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_q       <= '0;
      kr_q        <= '0;
      vx_q        <= '0;
      vy_q        <= '0;
      vw_q        <= '0;
      prod_q      <= '0;
      rx_q        <= '0;
      ry_q        <= '0;
      pose_x_q    <= '0;
      pose_y_q    <= '0;
      head_q      <= '0;
      pmag_q      <= '0;
      pneg_q      <= 1'b0;
      neg_q       <= 1'b0;
      hi_q        <= '0;
      rn_q        <= '0;
      acc_q       <= '0;
      mstep_q     <= '0;
      out_valid_q <= 1'b0;
      out_vx_q    <= '0;
      out_vy_q    <= '0;
      out_vw_q    <= '0;
      out_px_q    <= '0;
      out_py_q    <= '0;
      out_head_q  <= '0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
        out_vx_q    <= vx_q;
        out_vy_q    <= vy_q;
        out_vw_q    <= vw_q;
        out_px_q    <= pose_x_q;
        out_py_q    <= pose_y_q;
        out_head_q  <= head_q;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            req_q   <= req_i;
            state_q <= S_KR;
          end
        end
        S_KR: begin
          kr_q    <= 27'(WHEEL_K) * 27'(radius_i);
          state_q <= S_VX;
        end
        S_VX: begin
          vx_q    <= kin_sh[31:0];
          state_q <= S_VY;
        end
        S_VY: begin
          vy_q    <= kin_sh[31:0];
          state_q <= S_VW;
        end
        S_VW: begin
          neg_q   <= kin_prod[47];
          state_q <= S_DIVW;
        end
        S_DIVW: begin
          if (div_done) begin
            vw_q    <= sat32(q_s);
            state_q <= S_CORD;
          end
        end
        S_CORD: begin
          if (cord_done) begin
            state_q <= S_M1;
          end
        end
        S_M1: begin
          prod_q  <= mprod;
          state_q <= S_M2;
        end
        S_M2: begin
          rx_q    <= dsh[34:0];
          state_q <= S_M3;
        end
        S_M3: begin
          prod_q  <= mprod;
          state_q <= S_M4;
        end
        S_M4: begin
          ry_q    <= dsh[34:0];
          state_q <= S_XD;
        end
        S_XD: begin
          neg_q   <= pos_prod[55];
          rn_q    <= pos_abs[47:DT_POW2_SHIFT];
          acc_q   <= '0;
          mstep_q <= '0;
          state_q <= S_XM;
        end
        S_XM: begin
          acc_q   <= acc_q + pp_sh;
          mstep_q <= mstep_q + 2'd1;
          if (mstep_q == 2'd3) begin
            state_q <= S_XW;
          end
        end
        S_XW: begin
          pose_x_q <= sat48(psum);
          state_q  <= S_YD;
        end
        S_YD: begin
          neg_q   <= pos_prod[55];
          rn_q    <= pos_abs[47:DT_POW2_SHIFT];
          acc_q   <= '0;
          mstep_q <= '0;
          state_q <= S_YM;
        end
        S_YM: begin
          acc_q   <= acc_q + pp_sh;
          mstep_q <= mstep_q + 2'd1;
          if (mstep_q == 2'd3) begin
            state_q <= S_YW;
          end
        end
        S_YW: begin
          pose_y_q <= sat48(psum);
          state_q  <= S_H1;
        end
        S_H1: begin
          pneg_q  <= h_prod[52];
          pmag_q  <= h_abs[51:0];
          state_q <= S_H2;
        end
        S_H2: begin
          hi_q    <= hi_prod;
          state_q <= S_H3;
        end
        S_H3: begin
          head_q  <= pneg_q ? head_q - inc : head_q + inc;
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (load_out) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

### hdl/mecanum_odometry_integrator.sv
// The back end works on one request at a time and pops the next from the queue only after
// the result has been taken into the output register; its time per request is set mostly by the
// one-bit-per-cycle yaw rate divider and by the CORDIC.
// A two-entry queue accepts up to two requests while the back end is busy.
// Reset is asynchronous and active low; it clears the pose and heading to zero
// and loads the default wheel radius and lever sum.
module mecanum_odometry_integrator #(
  parameter int CORDIC_STEPS = moi_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] speed_front_left_i,
  input  logic signed [15:0] speed_front_right_i,
  input  logic signed [15:0] speed_rear_left_i,
  input  logic signed [15:0] speed_rear_right_i,
  input  logic [19:0]        elapsed_us_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] body_vel_x_o,
  output logic signed [31:0] body_vel_y_o,
  output logic signed [31:0] body_yaw_rate_o,
  output logic signed [47:0] position_x_o,
  output logic signed [47:0] position_y_o,
  output logic [31:0]        heading_angle_o
);
  import moi_pkg::*;

  logic [15:0] radius_q;
  logic [17:0] lever_q;
  logic        cfg_wr;
  moi_req_t    req;
  logic        req_valid, req_pop;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_LEVER) ? {14'd0, lever_q} : {16'd0, radius_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 16'd4981;
      lever_q  <= 18'd32440;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_LEVER) begin
        lever_q <= pwdata[17:0];
      end else begin
        radius_q <= pwdata[15:0];
      end
    end
  end

  moi_front u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .speed_front_left_i  (speed_front_left_i),
    .speed_front_right_i (speed_front_right_i),
    .speed_rear_left_i   (speed_rear_left_i),
    .speed_rear_right_i  (speed_rear_right_i),
    .elapsed_us_i        (elapsed_us_i),
    .req_valid_o         (req_valid),
    .req_o               (req),
    .req_pop_i           (req_pop)
  );

  moi_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_valid_i     (req_valid),
    .req_i           (req),
    .req_pop_o       (req_pop),
    .radius_i        (radius_q),
    .lever_i         (lever_q),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .body_vel_x_o    (body_vel_x_o),
    .body_vel_y_o    (body_vel_y_o),
    .body_yaw_rate_o (body_yaw_rate_o),
    .position_x_o    (position_x_o),
    .position_y_o    (position_y_o),
    .heading_angle_o (heading_angle_o)
  );

endmodule

### hdl/moi_checker.sv
`include "assert_macros.svh"

module moi_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [2:0]         paddr,
  input logic [31:0]        pwdata,
  input logic [31:0]        prdata,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] body_vel_x_o,
  input logic signed [47:0] position_x_o,
  input logic [31:0]        heading_angle_o
);

  `MOI_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `MOI_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(body_vel_x_o) && $stable(position_x_o) && $stable(heading_angle_o))
  `MOI_ASSERT_NOW(a_radius_rb, clk_i, rst_ni, (psel && penable && pwrite && !paddr[2]) ##1 (!paddr[2]) |-> (prdata[31:16] == 16'h0) && (prdata[15:0] == $past(pwdata[15:0])))
  `MOI_ASSERT_NOW(a_lever_rb, clk_i, rst_ni, (psel && penable && pwrite && paddr[2]) ##1 (paddr[2]) |-> (prdata[31:18] == 14'h0) && (prdata[17:0] == $past(pwdata[17:0])))

endmodule

bind mecanum_odometry_integrator moi_checker u_moi_checker (.*);

### tb/mecanum_odometry_integrator_tb.sv
module mecanum_odometry_integrator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import moi_pkg::*;

  localparam int          CORDIC_N   = CORDIC_STEPS_DEF;
  localparam logic [2:0]  ADDR_RADIUS = 3'd0;
  localparam logic [2:0]  ADDR_LEVER  = 3'd4;
  localparam int          DRAIN_CYCLES = 250;

  typedef struct {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] yaw_rate;
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic [31:0]        heading;
  } odom_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [15:0] speed_front_left_i = '0, speed_front_right_i = '0;
  logic signed [15:0] speed_rear_left_i = '0, speed_rear_right_i = '0;
  logic [19:0] elapsed_us_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] body_vel_x_o, body_vel_y_o, body_yaw_rate_o;
  logic signed [47:0] position_x_o, position_y_o;
  logic [31:0] heading_angle_o;

  mecanum_odometry_integrator uut (.*);

  always #5 clk_i = ~clk_i;

  const longint atan_q30[ATAN_ENTRIES] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81};

  logic [15:0] cfg_radius = 16'd4981;
  logic [17:0] cfg_lever = 18'd32440;
  longint odo_x = 0, odo_y = 0;
  logic [31:0] odo_heading = '0;

  odom_t expected_odom[$];
  int errors = 0;
  int idle_pct = 0, stall_pct = 0;

  function automatic longint clamp(longint v, int bits);
    longint hi, lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic void heading_trig(logic [31:0] ang, output longint c, output longint s);
    logic flip;
    longint x, y, z, xs, ys;
    logic [31:0] sum;
    sum = ang + 32'h4000_0000;
    flip = sum[31];
    if (flip) ang = ang - 32'h8000_0000;
    x = CORDIC_X0;
    y = 0;
    z = longint'(signed'(ang));
    for (int i = 0; i < CORDIC_N && i < ATAN_ENTRIES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - atan_q30[i];
      end else begin
        x = x + ys; y = y - xs; z = z + atan_q30[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic [31:0] heading_advance(longint p);
    longint unsigned mag, hi, lo;
    logic [31:0] inc;
    mag = p < 0 ? longint'(-p) : p;
    hi = (mag >> 20) * longint'(HEAD_CQ);
    lo = (mag & 64'hFFFFF) * longint'(HEAD_CQ);
    inc = 32'((hi + (lo >> 20)) >> HEAD_SHIFT);
    return p < 0 ? 32'd0 - inc : inc;
  endfunction

  function automatic odom_t advance_odometry(logic signed [15:0] fl, logic signed [15:0] fr,
                                             logic signed [15:0] rl, logic signed [15:0] rr,
                                             logic [19:0] dt);
    longint w0, w1, w2, w3, sx, sy, sw, r, lev, vx, vy, vw, c, s, rx, ry, t;
    odom_t o;
    w0 = longint'(fl) * WHEEL_K;
    w1 = -longint'(fr) * WHEEL_K;
    w2 = -longint'(rl) * WHEEL_K;
    w3 = longint'(rr) * WHEEL_K;
    t = longint'(dt);
    r = longint'(cfg_radius);
    lev = cfg_lever == 0 ? 1 : longint'(cfg_lever);
    sx = w0 + w1 + w2 + w3;
    sy = -w0 + w1 + w2 - w3;
    sw = -w0 + w1 - w2 + w3;
    vx = clamp(sx * r / 262144, 32);
    vy = clamp(sy * r / 262144, 32);
    vw = clamp(sw * r / (4 * lev), 32);
    heading_trig(odo_heading, c, s);
    rx = (vx * c - vy * s) / (longint'(1) <<< Q30_SHIFT);
    ry = (vx * s + vy * c) / (longint'(1) <<< Q30_SHIFT);
    odo_x = clamp(odo_x + rx * t / 1000000, 48);
    odo_y = clamp(odo_y + ry * t / 1000000, 48);
    odo_heading = odo_heading + heading_advance(vw * t);
    o.vel_x = vx[31:0];
    o.vel_y = vy[31:0];
    o.yaw_rate = vw[31:0];
    o.pos_x = odo_x[47:0];
    o.pos_y = odo_y[47:0];
    o.heading = odo_heading;
    return o;
  endfunction

  task automatic send_speeds(logic signed [15:0] fl, logic signed [15:0] fr,
                             logic signed [15:0] rl, logic signed [15:0] rr, logic [19:0] dt);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    speed_front_left_i <= fl;
    speed_front_right_i <= fr;
    speed_rear_left_i <= rl;
    speed_rear_right_i <= rr;
    elapsed_us_i <= dt;
    do @(posedge clk_i); while (in_stall_o);
    expected_odom.push_back(advance_odometry(fl, fr, rl, rr, dt));
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_odom.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= addr; pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    pwrite <= 1'b0; penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata != (addr == ADDR_RADIUS ? 32'(data[15:0]) : 32'(data[17:0]))) begin
      $display("%0t register read at %0d: expected %0h actual %0h", $time, addr,
               addr == ADDR_RADIUS ? 32'(data[15:0]) : 32'(data[17:0]), prdata);
      errors++;
    end
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0;
    if (addr == ADDR_RADIUS) cfg_radius = data[15:0];
    else cfg_lever = data[17:0];
    @(negedge clk_i);
  endtask

  task automatic set_geometry(logic [15:0] radius, logic [17:0] lever);
    wait_idle();
    write_reg(ADDR_RADIUS, {16'($urandom_range(65535)), radius});
    write_reg(ADDR_LEVER, {14'($urandom_range(16383)), lever});
  endtask

  function automatic logic [19:0] pick_elapsed();
    case ($urandom_range(9))
      0: return 20'd0;
      1: return 20'hFFFFF;
      2, 3: return 20'($urandom_range(1048575));
      default: return 20'($urandom_range(21000, 19000));
    endcase
  endfunction

  function automatic logic signed [15:0] pick_speed(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'(signed'($urandom_range(400)) - 200);
      default: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
    endcase
  endfunction

  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  always @(posedge clk_i) begin
    odom_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_odom.size() == 0) begin
        $display("%0t unexpected result: expected none actual vx %0d", $time, body_vel_x_o);
        errors++;
      end else begin
        e = expected_odom.pop_front();
        if (body_vel_x_o !== e.vel_x) begin
          $display("%0t body_vel_x: expected %0d actual %0d", $time, e.vel_x, body_vel_x_o);
          errors++;
        end
        if (body_vel_y_o !== e.vel_y) begin
          $display("%0t body_vel_y: expected %0d actual %0d", $time, e.vel_y, body_vel_y_o);
          errors++;
        end
        if (body_yaw_rate_o !== e.yaw_rate) begin
          $display("%0t body_yaw_rate: expected %0d actual %0d", $time, e.yaw_rate,
                   body_yaw_rate_o);
          errors++;
        end
        if (position_x_o !== e.pos_x) begin
          $display("%0t position_x: expected %0d actual %0d", $time, e.pos_x, position_x_o);
          errors++;
        end
        if (position_y_o !== e.pos_y) begin
          $display("%0t position_y: expected %0d actual %0d", $time, e.pos_y, position_y_o);
          errors++;
        end
        if (heading_angle_o !== e.heading) begin
          $display("%0t heading_angle: expected %0h actual %0h", $time, e.heading,
                   heading_angle_o);
          errors++;
        end
      end
    end
  end

  task automatic test_wheel_extremes();
    send_speeds(0, 0, 0, 0, 20000);
    send_speeds(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 20000);
    send_speeds(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 20000);
    send_speeds(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 20'hFFFFF);
    send_speeds(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 20'hFFFFF);
    send_speeds(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 20'h55555);
    send_speeds(16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 20'hAAAAA);
    send_speeds(1000, -1000, 1000, -1000, 0);
    send_speeds(-1, 1, -1, 1, 1);
  endtask

  task automatic test_heading_wrap();
    repeat (6) send_speeds(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 20'hFFFFF);
    repeat (4) send_speeds(300, 100, -100, 300, 20000);
  endtask

  task automatic test_geometry_extremes();
    set_geometry(16'hFFFF, 18'd1);
    send_speeds(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 20'hFFFFF);
    send_speeds(500, 200, -300, 100, 20000);
    set_geometry(16'd0, 18'd32440);
    send_speeds(16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 20'hFFFFF);
    set_geometry(16'd1, 18'd0);
    send_speeds(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 20000);
    set_geometry(16'hFFFF, 18'h3FFFF);
    send_speeds(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 20000);
    send_speeds(300, -300, 300, -300, 20000);
    set_geometry(16'd4981, 18'd32440);
  endtask

  task automatic test_random_driving();
    int mode;
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = phase == 1 ? 51 : (phase == 3 ? 14 : 0);
      stall_pct = phase == 2 ? 51 : (phase == 3 ? 14 : 0);
      if (phase != 0)
        set_geometry(16'($urandom_range(65535, 1)), 18'($urandom_range(262143, 1)));
      repeat (250) begin
        mode = $urandom_range(9) == 0 ? 2 : ($urandom_range(1) ? 0 : 1);
        send_speeds(pick_speed(mode), pick_speed(mode), pick_speed(mode), pick_speed(mode),
                    pick_elapsed());
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_wheel_extremes();
    test_heading_wrap();
    test_geometry_extremes();
    test_random_driving();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && expected_odom.size() == 0) $display("mecanum_odometry_integrator_tb: PASS");
    else $display("mecanum_odometry_integrator_tb: FAIL");
    $finish;
  end

  initial begin
    #50ms;
    $display("mecanum_odometry_integrator_tb: FAIL");
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/moi_pkg.sv
hdl/moi_front.sv
hdl/moi_div.sv
hdl/moi_cordic.sv
hdl/moi_back.sv
hdl/mecanum_odometry_integrator.sv
hdl/moi_checker.sv
tb/mecanum_odometry_integrator_tb.sv
